// ===== hdl/bcr_pkg.sv =====
// Shared types and constants of the bicubic line resampler.
// Used by the front end, the command queue, the tap engine and the top level.
package bcr_pkg;

    // field widths of the beat interface
    localparam int POS_W    = 11;
    localparam int TAP_W    = 4;
    localparam int WEIGHT_W = 32;
    localparam int CNT_W    = 5;
    localparam int CHAN_W   = 8;
    localparam int RGB_W    = 3 * CHAN_W;
    localparam int SPAN_W   = POS_W + CNT_W;

    // largest channel value after clipping
    localparam int CHAN_MAX = 255;

    // default sizes handed to the top level
    localparam int DEF_LINE_LEN  = 2048;
    localparam int DEF_OUT_LEN   = 2048;
    localparam int DEF_MAX_TAPS  = 16;
    localparam int DEF_FRAC_BITS = 22;

    // command queue between front end and tap engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_SPAN    = 2'd1,
        OP_PIXEL   = 2'd2,
        OP_COMPUTE = 2'd3
    } t_op;

    // one classified beat as it travels through the queue
    typedef struct packed {
        t_op                        op;
        logic                       ok;     // target index in range
        logic [POS_W-1:0]           position;
        logic [TAP_W-1:0]           tap;
        logic signed [WEIGHT_W-1:0] weight;
        logic [POS_W-1:0]           span_start;
        logic [CNT_W-1:0]           span_count;
        logic [RGB_W-1:0]           rgb;    // blue, green, red from msb down
    } t_cmd;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

// ===== hdl/bcr_front.sv =====
// Front end: takes input beats, range-checks the target index and packs a command.
// Depends on bcr_pkg; feeds bcr_queue.
module bcr_front
    import bcr_pkg::*;
#(
    parameter int LINE_LEN = DEF_LINE_LEN,
    parameter int OUT_LEN  = DEF_OUT_LEN,
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                       i_valid,
    input  logic [1:0]                 i_op,
    input  logic [POS_W-1:0]           i_position,
    input  logic [TAP_W-1:0]           i_tap,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    input  logic [POS_W-1:0]           i_span_start,
    input  logic [CNT_W-1:0]           i_span_count,
    input  logic [CHAN_W-1:0]          i_red_in,
    input  logic [CHAN_W-1:0]          i_green_in,
    input  logic [CHAN_W-1:0]          i_blue_in,
    input  t_q_status                  i_q_status,
    output logic                       o_stall,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    logic out_ok;
    logic line_ok;
    logic tap_ok;
    t_op  op;

    assign op      = t_op'(i_op);
    assign out_ok  = (32'(i_position) < OUT_LEN);
    assign line_ok = (32'(i_position) < LINE_LEN);
    assign tap_ok  = (32'(i_tap) < MAX_TAPS);

    // stall only on a full queue
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // classify the beat
    always_comb begin
        o_cmd.op         = op;
        o_cmd.position   = i_position;
        o_cmd.tap        = i_tap;
        o_cmd.weight     = i_weight;
        o_cmd.span_start = i_span_start;
        o_cmd.span_count = i_span_count;
        o_cmd.rgb        = {i_blue_in, i_green_in, i_red_in};
        case (op)
            OP_WEIGHT:  o_cmd.ok = out_ok && tap_ok;
            OP_SPAN:    o_cmd.ok = out_ok;
            OP_PIXEL:   o_cmd.ok = line_ok;
            OP_COMPUTE: o_cmd.ok = out_ok;
            default:    o_cmd.ok = 1'b0;
        endcase
    end

endmodule

// ===== hdl/bcr_queue.sv =====
// Short command queue that decouples the front end from the tap engine.
// Depends on bcr_pkg.
module bcr_queue
    import bcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (32'(p) == QUEUE_DEPTH - 1) r = '0;
        else                          r = p + QPTR_W'(1);
        return r;
    endfunction

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)      n_count = r_count + QCNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_status.count = r_count;

endmodule

// ===== hdl/bcr_engine.sv =====
// Tap engine: owns the line, span and weight stores, runs writes and the
// multiply-accumulate walk over a span, and holds the result register.
// Depends on bcr_pkg; takes commands from bcr_queue.
module bcr_engine
    import bcr_pkg::*;
#(
    parameter int LINE_LEN  = DEF_LINE_LEN,
    parameter int OUT_LEN   = DEF_OUT_LEN,
    parameter int MAX_TAPS  = DEF_MAX_TAPS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [POS_W-1:0]  o_position,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue
);

    localparam int LADDR_W = $clog2(LINE_LEN);
    localparam int SADDR_W = $clog2(OUT_LEN);
    localparam int WDEPTH  = OUT_LEN * MAX_TAPS;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int TAP_CW  = $clog2(MAX_TAPS + 1);
    localparam int SRC_W   = POS_W + TAP_CW;
    localparam int PROD_W  = WEIGHT_W + CHAN_W + 1;
    localparam int ACC_W   = PROD_W + TAP_CW + 1;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SPAN  = 5'b00010,
        S_TAP   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [WADDR_W-1:0] r_wbase, n_wbase;
    logic [TAP_CW-1:0]  r_k,     n_k;
    logic [TAP_CW-1:0]  r_n,     n_n;
    logic [POS_W-1:0]   r_start, n_start;

    // stores
    logic [RGB_W-1:0]           r_line_mem [LINE_LEN];
    logic [SPAN_W-1:0]          r_span_mem [OUT_LEN];
    logic signed [WEIGHT_W-1:0] r_wt_mem   [WDEPTH];

    logic [RGB_W-1:0]           r_line_q;
    logic signed [WEIGHT_W-1:0] r_wt_q;
    logic [SPAN_W-1:0]          r_span_q;

    logic r_p1_v, r_p2_v;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc  [3];

    logic r_out_valid;

    // decoded controls
    logic               line_we, span_we, wt_we, span_re;
    logic               tap_issue, tap_active;
    logic               acc_load, acc_bias, out_load;
    logic [SRC_W-1:0]   src;
    logic [WADDR_W-1:0] wt_waddr;
    logic [CNT_W-1:0]   span_cnt;

    function automatic logic [CHAN_W-1:0] clip_chan(input logic signed [ACC_W-1:0] a);
        logic [CHAN_W-1:0] r;
        if (a[ACC_W-1])                         r = '0;
        else if (|a[ACC_W-2:FRAC_BITS+CHAN_W])  r = CHAN_W'(CHAN_MAX);
        else                                    r = a[FRAC_BITS+CHAN_W-1:FRAC_BITS];
        return r;
    endfunction

    assign src        = SRC_W'(r_start) + SRC_W'(r_k);
    assign tap_active = (32'(src) < LINE_LEN);
    assign wt_waddr   = WADDR_W'(32'(i_cmd.position) * MAX_TAPS + 32'(i_cmd.tap));
    assign span_cnt   = r_span_q[CNT_W-1:0];

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_wbase   = r_wbase;
        n_k       = r_k;
        n_n       = r_n;
        n_start   = r_start;
        o_pop     = 1'b0;
        line_we   = 1'b0;
        span_we   = 1'b0;
        wt_we     = 1'b0;
        span_re   = 1'b0;
        tap_issue = 1'b0;
        acc_load  = 1'b0;
        acc_bias  = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_WEIGHT: wt_we   = i_cmd.ok;
                        OP_SPAN:   span_we = i_cmd.ok;
                        OP_PIXEL:  line_we = i_cmd.ok;
                        OP_COMPUTE: begin
                            n_pos    = i_cmd.position;
                            acc_load = 1'b1;
                            acc_bias = i_cmd.ok;
                            n_wbase  = WADDR_W'(32'(i_cmd.position) * MAX_TAPS);
                            if (i_cmd.ok) begin
                                span_re = 1'b1;
                                n_state = S_SPAN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SPAN: begin
                // saturate the tap count
                n_n     = (32'(span_cnt) > MAX_TAPS) ? TAP_CW'(MAX_TAPS) : TAP_CW'(span_cnt);
                n_start = r_span_q[SPAN_W-1:CNT_W];
                n_k     = '0;
                n_state = S_TAP;
            end
            S_TAP: begin
                if (r_k == r_n) begin
                    n_state = S_DRAIN;
                end else begin
                    tap_issue = 1'b1;
                    n_k       = r_k + TAP_CW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_p1_v && !r_p2_v) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1_v  <= tap_issue && tap_active;
            r_p2_v  <= r_p1_v;
            if (out_load)      r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_wbase <= n_wbase;
        r_k     <= n_k;
        r_n     <= n_n;
        r_start <= n_start;
    end

    // line store: pixel writes, tap reads
    always_ff @(posedge i_clk) begin
        if (line_we)   r_line_mem[LADDR_W'(i_cmd.position)] <= i_cmd.rgb;
        if (tap_issue) r_line_q <= r_line_mem[LADDR_W'(src)];
    end

    // span store
    always_ff @(posedge i_clk) begin
        if (span_we) r_span_mem[SADDR_W'(i_cmd.position)] <= {i_cmd.span_start, i_cmd.span_count};
        if (span_re) r_span_q <= r_span_mem[SADDR_W'(i_cmd.position)];
    end

    // weight store
    always_ff @(posedge i_clk) begin
        if (wt_we)     r_wt_mem[wt_waddr] <= i_cmd.weight;
        if (tap_issue) r_wt_q <= r_wt_mem[r_wbase + WADDR_W'(r_k)];
    end

    // multiply then accumulate, one tap per cycle
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= $signed({1'b0, r_line_q[c*CHAN_W +: CHAN_W]}) * r_wt_q;
            if (acc_load)    r_acc[c] <= acc_bias ? ROUND_BIAS : '0;
            else if (r_p2_v) r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_position <= r_pos;
            o_red      <= clip_chan(r_acc[0]);
            o_green    <= clip_chan(r_acc[1]);
            o_blue     <= clip_chan(r_acc[2]);
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== hdl/bicubic_line_resampler.sv =====
// Bicubic line resampler: one fixed-point pass over a line of RGB pixels.
// The tap engine runs weight, span and pixel writes straight from its idle state.
// A compute runs from queue head through the span read, the tap walk (count saturated at
// MAX_TAPS), the drain and the result load, which waits while the output stalls.
// A four-entry queue lets the front end keep taking beats meanwhile.
// Reset clears control state and the queue; the three stores are undefined until written.
module bicubic_line_resampler
    import bcr_pkg::*;
#(
    parameter int LINE_LEN  = DEF_LINE_LEN,
    parameter int OUT_LEN   = DEF_OUT_LEN,
    parameter int MAX_TAPS  = DEF_MAX_TAPS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_op,
    input  logic [POS_W-1:0]           i_position,
    input  logic [TAP_W-1:0]           i_tap,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    input  logic [POS_W-1:0]           i_span_start,
    input  logic [CNT_W-1:0]           i_span_count,
    input  logic [CHAN_W-1:0]          i_red_in,
    input  logic [CHAN_W-1:0]          i_green_in,
    input  logic [CHAN_W-1:0]          i_blue_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [POS_W-1:0]           o_out_position,
    output logic [CHAN_W-1:0]          o_out_red,
    output logic [CHAN_W-1:0]          o_out_green,
    output logic [CHAN_W-1:0]          o_out_blue
);

    t_cmd      front_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    bcr_front #(
        .LINE_LEN (LINE_LEN),
        .OUT_LEN  (OUT_LEN),
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_tap        (i_tap),
        .i_weight     (i_weight),
        .i_span_start (i_span_start),
        .i_span_count (i_span_count),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_q_status   (q_status),
        .o_stall      (o_stall),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    bcr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    bcr_engine #(
        .LINE_LEN  (LINE_LEN),
        .OUT_LEN   (OUT_LEN),
        .MAX_TAPS  (MAX_TAPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_position (o_out_position),
        .o_red      (o_out_red),
        .o_green    (o_out_green),
        .o_blue     (o_out_blue)
    );

    // queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_status.count) <= QUEUE_DEPTH)
        else $error("command queue overfilled");

    // the engine pops only a queue that holds a beat
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    // an accepted input beat always finds room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !q_status.full)
        else $error("input beat accepted into full queue");

    // reset leaves no result pending and an empty queue
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && q_status.empty))
        else $error("state not cleared by reset");

endmodule

// ===== bench/bicubic_line_resampler_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bicubic_line_resampler: a directed table, then random
// weight, span and pixel writes with compute requests, checked against the table
// or a local fixed-point predictor. Depends on bcr_pkg and the RTL top level only.

module bicubic_line_resampler_test;
    import bcr_pkg::*;

    localparam int LINE_LEN  = DEF_LINE_LEN;
    localparam int OUT_LEN   = DEF_OUT_LEN;
    localparam int MAX_TAPS  = DEF_MAX_TAPS;
    localparam int FRAC_BITS = DEF_FRAC_BITS;

    localparam int PLAN_ROWS    = 22;
    localparam int HOLD_CYCLES  = 400;   // long output hold-off to back up the queue
    localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 40;    // wait after the last awaited result

    typedef struct packed {
        t_op                 op;
        logic [POS_W-1:0]    position;
        logic [TAP_W-1:0]    tap;
        logic [WEIGHT_W-1:0] weight;
        logic [POS_W-1:0]    span_start;
        logic [CNT_W-1:0]    span_count;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
    } t_beat;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_result;

    // directed row: rgb and want are {red, green, blue}
    typedef struct packed {
        t_op                 op;
        logic [POS_W-1:0]    position;
        logic [TAP_W-1:0]    tap;
        logic [WEIGHT_W-1:0] weight;
        logic [POS_W-1:0]    span_start;
        logic [CNT_W-1:0]    span_count;
        logic [RGB_W-1:0]    rgb;
        logic                known;
        logic [RGB_W-1:0]    want;
    } t_plan_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [1:0]                 i_op;
    logic [POS_W-1:0]           i_position;
    logic [TAP_W-1:0]           i_tap;
    logic signed [WEIGHT_W-1:0] i_weight;
    logic [POS_W-1:0]           i_span_start;
    logic [CNT_W-1:0]           i_span_count;
    logic [CHAN_W-1:0]          i_red_in;
    logic [CHAN_W-1:0]          i_green_in;
    logic [CHAN_W-1:0]          i_blue_in;
    logic                       o_valid;
    logic                       i_stall;
    logic [POS_W-1:0]           o_out_position;
    logic [CHAN_W-1:0]          o_out_red;
    logic [CHAN_W-1:0]          o_out_green;
    logic [CHAN_W-1:0]          o_out_blue;

    bicubic_line_resampler dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // predictor copy of the three stores
    logic [RGB_W-1:0] pixel_mem [LINE_LEN];
    logic [POS_W-1:0] span_first [OUT_LEN];
    logic [CNT_W-1:0] span_taps [OUT_LEN];
    int               weight_mem [OUT_LEN * MAX_TAPS];

    // which entries have been written, so no compute reads an undefined one
    bit pix_written [LINE_LEN];
    bit span_written [OUT_LEN];
    bit wt_written [OUT_LEN * MAX_TAPS];

    t_result awaited_pixels [$];
    int      resampled_positions [$];

    int beats_sent;
    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int rx_hold_len;
    int quiet_cycles;

    // round-down shift and clip of one channel accumulator
    function automatic logic [CHAN_W-1:0] clip_channel(input longint acc);
        longint v;
        if (acc < 0)
            return '0;
        v = acc >>> FRAC_BITS;
        if (v > CHAN_MAX)
            return CHAN_W'(CHAN_MAX);
        return CHAN_W'(v);
    endfunction

    // applies one beat to the predictor state; returns 1 with the pixel for a compute
    function automatic bit predict_resample(input t_beat b, output t_result r);
        longint           acc_r, acc_g, acc_b, w;
        int               n, k, src;
        logic [RGB_W-1:0] px;
        r = '0;
        r.position = b.position;
        case (b.op)
            OP_WEIGHT: begin
                if (b.position < OUT_LEN && b.tap < MAX_TAPS)
                    weight_mem[int'(b.position) * MAX_TAPS + int'(b.tap)] = b.weight;
            end
            OP_SPAN: begin
                if (b.position < OUT_LEN) begin
                    span_first[b.position] = b.span_start;
                    span_taps[b.position]  = b.span_count;
                end
            end
            OP_PIXEL: begin
                if (b.position < LINE_LEN)
                    pixel_mem[b.position] = {b.red, b.green, b.blue};
            end
            default: ;
        endcase
        if (b.op != OP_COMPUTE)
            return 1'b0;
        // each channel starts at half an output LSB
        acc_r = longint'(1) <<< (FRAC_BITS - 1);
        acc_g = acc_r;
        acc_b = acc_r;
        if (b.position < OUT_LEN) begin
            n = (span_taps[b.position] > MAX_TAPS) ? MAX_TAPS : int'(span_taps[b.position]);
            for (k = 0; k < n; k++) begin
                src = int'(span_first[b.position]) + k;
                // taps past the line end add nothing
                if (src < LINE_LEN) begin
                    w  = longint'(weight_mem[int'(b.position) * MAX_TAPS + k]);
                    px = pixel_mem[src];
                    acc_r += longint'(px[3*CHAN_W-1 -: CHAN_W]) * w;
                    acc_g += longint'(px[2*CHAN_W-1 -: CHAN_W]) * w;
                    acc_b += longint'(px[CHAN_W-1 -: CHAN_W]) * w;
                end
            end
        end else begin
            acc_r = 0;
            acc_g = 0;
            acc_b = 0;
        end
        r.red   = clip_channel(acc_r);
        r.green = clip_channel(acc_g);
        r.blue  = clip_channel(acc_b);
        return 1'b1;
    endfunction

    // true when a compute at p reads only written entries
    function automatic bit sources_written(input int p);
        int n, k, src;
        if (!span_written[p])
            return 1'b0;
        n = (span_taps[p] > MAX_TAPS) ? MAX_TAPS : int'(span_taps[p]);
        for (k = 0; k < n; k++) begin
            src = int'(span_first[p]) + k;
            if (src < LINE_LEN && (!wt_written[p * MAX_TAPS + k] || !pix_written[src]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // every field random; callers pin the ones that matter
    function automatic t_beat random_beat();
        t_beat b;
        b.op         = t_op'($urandom_range(OP_COMPUTE));
        b.position   = POS_W'($urandom_range(2**POS_W - 1));
        b.tap        = TAP_W'($urandom_range(2**TAP_W - 1));
        b.weight     = $urandom;
        b.span_start = POS_W'($urandom_range(2**POS_W - 1));
        b.span_count = CNT_W'($urandom_range(2**CNT_W - 1));
        b.red        = CHAN_W'($urandom_range(CHAN_MAX));
        b.green      = CHAN_W'($urandom_range(CHAN_MAX));
        b.blue       = CHAN_W'($urandom_range(CHAN_MAX));
        return b;
    endfunction

    // mostly filter-like weights (-0.25 .. 0.5), some raw and some at the rails
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return WEIGHT_W'($urandom_range(3 << 20) - (1 << 20));
        endcase
    endfunction

    // drive one input beat, wait for it to be taken, then predict
    task automatic send_beat(input t_beat b, input bit known = 1'b0,
                             input t_result want = '0);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_op         = b.op;
        i_position   = b.position;
        i_tap        = b.tap;
        i_weight     = b.weight;
        i_span_start = b.span_start;
        i_span_count = b.span_count;
        i_red_in     = b.red;
        i_green_in   = b.green;
        i_blue_in    = b.blue;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (predict_resample(b, r)) begin
            if (known)
                r = want;
            awaited_pixels = {awaited_pixels, r};
        end
        case (b.op)
            OP_WEIGHT: wt_written[int'(b.position) * MAX_TAPS + int'(b.tap)] = 1'b1;
            OP_SPAN:   span_written[b.position] = 1'b1;
            OP_PIXEL:  pix_written[b.position] = 1'b1;
            default: ;
        endcase
        beats_sent++;
    endtask

    // weights, pixels and span of one output, then optionally its compute
    task automatic resample_sequence(input bit finish_it);
        t_beat b;
        int    p, first, taps, n, k;
        p = $urandom_range(OUT_LEN - 1);
        // one span in eight starts within MAX_TAPS of the end of the line
        if ($urandom_range(7) == 0)
            first = $urandom_range(LINE_LEN - 1, LINE_LEN - MAX_TAPS);
        else
            first = $urandom_range(LINE_LEN - 1);
        // mostly short spans, now and then any count the field holds
        if ($urandom_range(9) == 0)
            taps = $urandom_range(2**CNT_W - 1);
        else
            taps = $urandom_range(6, 1);
        n = (taps > MAX_TAPS) ? MAX_TAPS : taps;
        for (k = 0; k < n; k++) begin
            b          = random_beat();
            b.op       = OP_WEIGHT;
            b.position = POS_W'(p);
            b.tap      = TAP_W'(k);
            b.weight   = pick_weight();
            send_beat(b);
        end
        for (k = 0; k < n; k++) begin
            if (first + k < LINE_LEN && (!pix_written[first + k] || $urandom_range(1) == 1)) begin
                b          = random_beat();
                b.op       = OP_PIXEL;
                b.position = POS_W'(first + k);
                send_beat(b);
            end
        end
        b            = random_beat();
        b.op         = OP_SPAN;
        b.position   = POS_W'(p);
        b.span_start = POS_W'(first);
        b.span_count = CNT_W'(taps);
        send_beat(b);
        if (finish_it) begin
            b          = random_beat();
            b.op       = OP_COMPUTE;
            b.position = POS_W'(p);
            send_beat(b);
            resampled_positions = {resampled_positions, p};
        end
    endtask

    // random mix: full sequences, recomputes, broken sequences, stray writes
    task automatic run_random(input int beats);
        t_beat b;
        int    stop_at, pick, p;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                resample_sequence(1'b1);
            end else if (pick < 80 && resampled_positions.size() > 0) begin
                p = resampled_positions[$urandom_range(resampled_positions.size() - 1)];
                if (sources_written(p)) begin
                    b          = random_beat();
                    b.op       = OP_COMPUTE;
                    b.position = POS_W'(p);
                    send_beat(b);
                end else begin
                    resample_sequence(1'b1);
                end
            end else if (pick < 90) begin
                resample_sequence(1'b0);
            end else begin
                b    = random_beat();
                b.op = t_op'($urandom_range(OP_PIXEL));
                send_beat(b);
            end
        end
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", what);
    endtask

    // output side: random stall, or one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_stall = 1'b1;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end else begin
                i_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // compare every output beat with the oldest awaited pixel
    always @(posedge i_clk) begin : check_results
        t_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_out_position, o_out_red, o_out_green, o_out_blue};
            if (awaited_pixels.size() == 0) begin
                note_failure($sformatf("unexpected result at position %0d: %0d/%0d/%0d",
                    got.position, got.red, got.green, got.blue));
            end else begin
                want = awaited_pixels.pop_front();
                if (got.position !== want.position || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue)
                    note_failure($sformatf(
                        "expected pos %0d rgb %0d/%0d/%0d, got pos %0d rgb %0d/%0d/%0d",
                        want.position, want.red, want.green, want.blue,
                        got.position, got.red, got.green, got.blue));
            end
        end
    end

    // watchdog on beats moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("bicubic_line_resampler regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_plan_row plan [PLAN_ROWS];
        t_beat     b;
        int        i;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_WEIGHT;
        i_position    = '0;
        i_tap         = '0;
        i_weight      = '0;
        i_span_start  = '0;
        i_span_count  = '0;
        i_red_in      = '0;
        i_green_in    = '0;
        i_blue_in     = '0;
        beats_sent    = 0;
        fail_count    = 0;
        rx_hold_len   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 12;
        recv_idle_pct = 69;

        //            op          pos       tap    weight         start      count  rgb
        // largest positive weight saturates, zero channel stays at the rounding half
        plan[0]  = '{OP_WEIGHT,  11'd0,    4'd0,  32'h7FFF_FFFF, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[1]  = '{OP_PIXEL,   11'd0,    4'd0,  32'h0,         11'd0,    5'd0,  24'hFF0080,
                     1'b0, 24'h0};
        plan[2]  = '{OP_SPAN,    11'd0,    4'd0,  32'h0,         11'd0,    5'd1,  24'h0,
                     1'b0, 24'h0};
        plan[3]  = '{OP_COMPUTE, 11'd0,    4'd0,  32'h0,         11'd0,    5'd0,  24'h0,
                     1'b1, 24'hFF00FF};
        // most negative weight: negative sums clip to zero
        plan[4]  = '{OP_WEIGHT,  11'd1,    4'd0,  32'h8000_0000, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[5]  = '{OP_SPAN,    11'd1,    4'd0,  32'h0,         11'd0,    5'd1,  24'h0,
                     1'b0, 24'h0};
        plan[6]  = '{OP_COMPUTE, 11'd1,    4'd0,  32'h0,         11'd0,    5'd0,  24'h0,
                     1'b1, 24'h000000};
        // zero count gives black
        plan[7]  = '{OP_SPAN,    11'd2,    4'd0,  32'h0,         11'd2047, 5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[8]  = '{OP_COMPUTE, 11'd2,    4'd0,  32'h0,         11'd0,    5'd0,  24'h0,
                     1'b1, 24'h000000};
        // unity weight passes the pixel through
        plan[9]  = '{OP_WEIGHT,  11'd3,    4'd0,  32'h0040_0000, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[10] = '{OP_SPAN,    11'd3,    4'd0,  32'h0,         11'd0,    5'd1,  24'h0,
                     1'b0, 24'h0};
        plan[11] = '{OP_COMPUTE, 11'd3,    4'd0,  32'h0,         11'd0,    5'd0,  24'h0,
                     1'b1, 24'hFF0080};
        // last position, count saturating, span running off the line end
        plan[12] = '{OP_WEIGHT,  11'd2047, 4'd0,  32'h0040_0000, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[13] = '{OP_WEIGHT,  11'd2047, 4'd15, 32'hA5A5_A5A5, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[14] = '{OP_PIXEL,   11'd2047, 4'd0,  32'h0,         11'd0,    5'd0,  24'hC811FF,
                     1'b0, 24'h0};
        plan[15] = '{OP_SPAN,    11'd2047, 4'd0,  32'h0,         11'd2047, 5'd31, 24'h0,
                     1'b0, 24'h0};
        plan[16] = '{OP_COMPUTE, 11'd2047, 4'd0,  32'h0,         11'd0,    5'd0,  24'h0,
                     1'b1, 24'hC811FF};
        // two-tap blend with rounding, left to the predictor
        plan[17] = '{OP_WEIGHT,  11'd4,    4'd0,  32'h0030_0000, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[18] = '{OP_WEIGHT,  11'd4,    4'd1,  32'h0010_0000, 11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};
        plan[19] = '{OP_PIXEL,   11'd1,    4'd0,  32'h0,         11'd0,    5'd0,  24'h00FF01,
                     1'b0, 24'h0};
        plan[20] = '{OP_SPAN,    11'd4,    4'd0,  32'h0,         11'd0,    5'd2,  24'h0,
                     1'b0, 24'h0};
        plan[21] = '{OP_COMPUTE, 11'd4,    4'd0,  32'h0,         11'd0,    5'd0,  24'h0,
                     1'b0, 24'h0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (i = 0; i < PLAN_ROWS; i++) begin
            b = '{plan[i].op, plan[i].position, plan[i].tap, plan[i].weight,
                  plan[i].span_start, plan[i].span_count, plan[i].rgb[23:16],
                  plan[i].rgb[15:8], plan[i].rgb[7:0]};
            send_beat(b, plan[i].known, {plan[i].position, plan[i].want});
        end

        // random, input side mostly busy and output often stalled
        run_random(580);

        // random, input side often idle
        send_idle_pct = 69;
        recv_idle_pct = 12;
        run_random(580);

        // no idling; first a long output hold-off so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_len   = HOLD_CYCLES;
        repeat (8) resample_sequence(1'b1);
        run_random(530);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (awaited_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("bicubic_line_resampler regression: pass");
        end else begin
            $display("bicubic_line_resampler regression: fail");
        end
        $finish;
    end

endmodule
